// ===== src/brb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int DEPTH_LOG2 = 8;
    localparam int DEPTH      = 1 << DEPTH_LOG2;
    localparam int IDX_W      = DEPTH_LOG2;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 9;
    localparam int SIZE_W     = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // s_tdata: command[2:0], data_in[10:3], count[19:11], zero pad to 24 bits
    localparam int S_DATA_W = 24;
    // m_tdata: ok, data_out, amount, used_count, free_count, is_empty, is_full
    localparam int M_DATA_W = 40;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_DISCARD = 3'd3,
        CMD_RESET   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [CNT_W-1:0]  amount;
        logic [BYTE_W-1:0] used_count;
        logic [BYTE_W-1:0] free_count;
        logic              is_empty;
        logic              is_full;
        logic              from_ram;
    } result_meta_t;

    // Active ring mask; log2 size clamped to 1..DEPTH_LOG2
    function automatic logic [IDX_W-1:0] ring_mask(input logic [SIZE_W-1:0] size_log2);
        logic [SIZE_W-1:0] l;
        l = size_log2;
        if (l < SIZE_W'(1))
        begin
            l = SIZE_W'(1);
        end
        if (l > SIZE_W'(DEPTH_LOG2))
        begin
            l = SIZE_W'(DEPTH_LOG2);
        end
        return IDX_W'((1 << l) - 1);
    endfunction

endpackage

`default_nettype wire

// ===== src/brb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/brb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [brb_pkg::SIZE_W-1:0]        cfg_wdata,
    input  wire logic                              acc,
    input  wire logic [2:0]                        command,
    input  wire logic [brb_pkg::BYTE_W-1:0]        data_in,
    input  wire logic [brb_pkg::CNT_W-1:0]         count,
    output logic                                   ram_we,
    output logic      [brb_pkg::IDX_W-1:0]         ram_waddr,
    output logic      [brb_pkg::BYTE_W-1:0]        ram_wdata,
    output logic                                   ram_re,
    output logic      [brb_pkg::IDX_W-1:0]         ram_raddr,
    output brb_pkg::result_meta_t                  meta
);

    logic [brb_pkg::SIZE_W-1:0] size_log2_reg;
    logic [brb_pkg::IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [brb_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic [brb_pkg::IDX_W-1:0]  mask;
    logic [brb_pkg::IDX_W-1:0]  w, r, used, used_new, w_inc;
    logic [brb_pkg::CNT_W-1:0]  used_ext, disc_amt;
    logic                       ok, from_ram, do_write;
    logic [brb_pkg::CNT_W-1:0]  amount;
    logic [brb_pkg::IDX_W-1:0]  raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= brb_pkg::SIZE_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_log2_reg <= cfg_wdata;
            end
            if (acc)
            begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
            end
        end
    end

    always_comb
    begin
        mask     = brb_pkg::ring_mask(size_log2_reg);
        w        = wr_idx_reg & mask;
        r        = rd_idx_reg & mask;
        used     = (w - r) & mask;
        used_ext = brb_pkg::CNT_W'(used);
        w_inc    = (w + brb_pkg::IDX_W'(1)) & mask;
        disc_amt = (count > used_ext) ? used_ext : count;

        ok          = 1'b0;
        amount      = '0;
        from_ram    = 1'b0;
        do_write    = 1'b0;
        raddr       = r;
        wr_idx_next = w;
        rd_idx_next = r;

        case (brb_pkg::cmd_t'(command))
            brb_pkg::CMD_WRITE:
            begin
                if (w_inc != r)
                begin
                    do_write    = 1'b1;
                    wr_idx_next = w_inc;
                    ok          = 1'b1;
                    amount      = brb_pkg::CNT_W'(1);
                end
            end
            brb_pkg::CMD_READ:
            begin
                if (w != r)
                begin
                    from_ram    = 1'b1;
                    rd_idx_next = (r + brb_pkg::IDX_W'(1)) & mask;
                    ok          = 1'b1;
                    amount      = brb_pkg::CNT_W'(1);
                end
            end
            brb_pkg::CMD_PEEK:
            begin
                // offset is below used, so its low bits are enough
                raddr = (r + count[brb_pkg::IDX_W-1:0]) & mask;
                if (count < used_ext)
                begin
                    from_ram = 1'b1;
                    ok       = 1'b1;
                    amount   = brb_pkg::CNT_W'(1);
                end
            end
            brb_pkg::CMD_DISCARD:
            begin
                rd_idx_next = (r + disc_amt[brb_pkg::IDX_W-1:0]) & mask;
                ok          = 1'b1;
                amount      = disc_amt;
            end
            brb_pkg::CMD_RESET:
            begin
                wr_idx_next = '0;
                rd_idx_next = '0;
                ok          = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        used_new = (wr_idx_next - rd_idx_next) & mask;

        meta.ok         = ok;
        meta.amount     = amount;
        meta.used_count = brb_pkg::BYTE_W'(used_new);
        meta.free_count = brb_pkg::BYTE_W'(mask - used_new);
        meta.is_empty   = (wr_idx_next == rd_idx_next);
        meta.is_full    = (((wr_idx_next + brb_pkg::IDX_W'(1)) & mask) == rd_idx_next);
        meta.from_ram   = from_ram;
    end

    assign ram_we    = acc && do_write;
    assign ram_waddr = w;
    assign ram_wdata = data_in;
    assign ram_re    = acc;
    assign ram_raddr = raddr;

    a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> ((wr_idx_reg & ~$past(mask)) == '0) && ((rd_idx_reg & ~$past(mask)) == '0))
        else $error("index outside active ring");

    a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (command == brb_pkg::CMD_RESET) |=> (wr_idx_reg == '0) && (rd_idx_reg == '0))
        else $error("reset command left indices set");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (w_inc != r) && !meta.from_ram)
        else $error("store written while full");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(wr_idx_reg) && $stable(rd_idx_reg))
        else $error("indices moved without a beat");

endmodule

`default_nettype wire

// ===== src/byte_ring_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte FIFO on a circular store, one slot always kept empty.
// Input beats (s_*) carry a command: write, read, peek at an offset from the
// oldest byte, discard up to count bytes, or empty the FIFO. Each input beat
// gives exactly one output beat (m_*) with the outcome, data byte, amount and
// the fill status after the command.
// cfg_we/cfg_wdata set log2 of the active ring size (clamped to 1..8); write it
// only while idle and follow it with a reset command.
// Throughput: one beat per cycle unless the output stalls. The indices live in
// flops and the byte store is a single RAM with a registered read, so a command
// is decoded and its RAM access issued in the cycle it is accepted.
// An input beat passes the RAM read stage, then the output register, on its way
// to the output beat.
// Reset empties the FIFO and sets the ring size to 256; the store is not
// cleared. When m_tready is low the output register holds, the stage behind it
// fills, and s_tready drops until the output beat is taken.
module byte_ring_buffer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [brb_pkg::SIZE_W-1:0]        cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // command[2:0], data_in[10:3], count[19:11], zero[23:20]
    input  wire logic [brb_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // ok[0], data_out[8:1], amount[17:9], used_count[25:18],
    // free_count[33:26], is_empty[34], is_full[35], zero[39:36]
    output logic      [brb_pkg::M_DATA_W-1:0]      m_tdata
);

    logic                         acc;
    logic                         ram_we, ram_re;
    logic [brb_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [brb_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;
    brb_pkg::result_meta_t        meta;
    brb_pkg::result_meta_t        s2_meta_reg;
    logic                         s2_valid_reg, s2_valid_next;
    logic                         m_valid_reg, m_valid_next;
    logic [brb_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                         s2_adv;
    logic [brb_pkg::BYTE_W-1:0]   data_out;

    assign s2_adv   = s2_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s2_valid_reg || s2_adv;
    assign acc      = s_tvalid && s_tready;

    brb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .command   (s_tdata[2:0]),
        .data_in   (s_tdata[10:3]),
        .count     (s_tdata[19:11]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .meta      (meta)
    );

    brb_ram #(
        .WIDTH (brb_pkg::BYTE_W),
        .DEPTH (brb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s2_valid_next = acc ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        m_valid_next  = s2_adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        data_out      = s2_meta_reg.from_ram ? ram_rdata : '0;
        m_data_next   = {4'd0,
                         s2_meta_reg.is_full,
                         s2_meta_reg.is_empty,
                         s2_meta_reg.free_count,
                         s2_meta_reg.used_count,
                         s2_meta_reg.amount,
                         data_out,
                         s2_meta_reg.ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s2_meta_reg <= meta;
        end
        if (s2_adv)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s2_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled with room downstream");

    a_beat_flows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s2_valid_reg)
        else $error("accepted beat lost before output stage");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |=>
            s2_valid_reg && (!s2_meta_reg.from_ram || $stable(ram_rdata)))
        else $error("stalled RAM data not held");

endmodule

`default_nettype wire

// ===== dv/byte_ring_buffer_tb.sv =====
`timescale 1ns / 1ps

module byte_ring_buffer_tb;
    import brb_pkg::*;

    // command codes outside the defined set; the block must treat them as no-ops
    localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
    localparam int         SETTLE_CYCLES = 6;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  amount;
        logic [BYTE_W-1:0] used;
        logic [BYTE_W-1:0] free;
        logic              empty;
        logic              full;
    } ring_status_t;

    typedef enum { FILL, DRAIN, MIXED } burst_kind_t;

    // Mirror of the ring: byte store, head/tail and active size, plus the
    // statuses still owed by the block.
    class ring_scoreboard;
        logic [BYTE_W-1:0] ring_mem [DEPTH];
        logic [IDX_W-1:0]  head;
        logic [IDX_W-1:0]  tail;
        logic [SIZE_W-1:0] size_log2;
        ring_status_t      answers_due [$];
        int                errors;

        function new();
            head      = '0;
            tail      = '0;
            size_log2 = SIZE_RESET;
            errors    = 0;
        endfunction

        function logic [IDX_W-1:0] mask();
            int l;
            l = int'(size_log2);
            if (l < 1)
            begin
                l = 1;
            end
            if (l > DEPTH_LOG2)
            begin
                l = DEPTH_LOG2;
            end
            return IDX_W'((1 << l) - 1);
        endfunction

        function int fill();
            logic [IDX_W-1:0] u;
            u = (head - tail) & mask();
            return int'(u);
        endfunction

        function void note(logic [2:0] cmd, logic [BYTE_W-1:0] din, logic [CNT_W-1:0] cnt);
            ring_status_t     res;
            logic [IDX_W-1:0] m;
            logic [IDX_W-1:0] w;
            logic [IDX_W-1:0] r;
            logic [IDX_W-1:0] u;
            logic [IDX_W-1:0] amt;
            m   = mask();
            w   = head & m;
            r   = tail & m;
            u   = (w - r) & m;
            res = '0;
            case (cmd)
                CMD_WRITE:
                begin
                    if ((IDX_W'(w + 1) & m) != r)
                    begin
                        ring_mem[w] = din;
                        w           = IDX_W'(w + 1) & m;
                        res.ok      = 1'b1;
                        res.amount  = CNT_W'(1);
                    end
                end
                CMD_READ:
                begin
                    if (w != r)
                    begin
                        res.data   = ring_mem[r];
                        r          = IDX_W'(r + 1) & m;
                        res.ok     = 1'b1;
                        res.amount = CNT_W'(1);
                    end
                end
                CMD_PEEK:
                begin
                    if (cnt < CNT_W'(u))
                    begin
                        res.data   = ring_mem[IDX_W'(r + cnt[IDX_W-1:0]) & m];
                        res.ok     = 1'b1;
                        res.amount = CNT_W'(1);
                    end
                end
                CMD_DISCARD:
                begin
                    amt        = (cnt > CNT_W'(u)) ? u : cnt[IDX_W-1:0];
                    r          = IDX_W'(r + amt) & m;
                    res.ok     = 1'b1;
                    res.amount = CNT_W'(amt);
                end
                CMD_RESET:
                begin
                    w      = '0;
                    r      = '0;
                    res.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            head      = w;
            tail      = r;
            u         = (w - r) & m;
            res.used  = u;
            res.free  = m - u;
            res.empty = (w == r);
            res.full  = (IDX_W'(w + 1) & m) == r;
            answers_due.push_back(res);
        endfunction

        task report(string what, int got, int want);
            $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
            errors++;
        endtask

        task check(logic [M_DATA_W-1:0] beat);
            ring_status_t exp;
            if (answers_due.size() == 0)
            begin
                report("unexpected output beat", 1, 0);
                return;
            end
            exp = answers_due.pop_front();
            if (beat[0] !== exp.ok)
            begin
                report("ok", int'(beat[0]), int'(exp.ok));
            end
            if (beat[8:1] !== exp.data)
            begin
                report("data_out", int'(beat[8:1]), int'(exp.data));
            end
            if (beat[17:9] !== exp.amount)
            begin
                report("amount", int'(beat[17:9]), int'(exp.amount));
            end
            if (beat[25:18] !== exp.used)
            begin
                report("used_count", int'(beat[25:18]), int'(exp.used));
            end
            if (beat[33:26] !== exp.free)
            begin
                report("free_count", int'(beat[33:26]), int'(exp.free));
            end
            if (beat[34] !== exp.empty)
            begin
                report("is_empty", int'(beat[34]), int'(exp.empty));
            end
            if (beat[35] !== exp.full)
            begin
                report("is_full", int'(beat[35]), int'(exp.full));
            end
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [SIZE_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    bit                  steady    = 1'b0;

    ring_scoreboard sb = new();

    byte_ring_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        if (p < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (p < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_op(logic [2:0] cmd, logic [BYTE_W-1:0] din, logic [CNT_W-1:0] cnt);
        int n;
        n = steady ? 0 : pause_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 20){1'b0}}, cnt, din, cmd};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note(cmd, din, cnt);
    endtask

    // hold off the sender until every status beat is back, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.size_log2 = v;
    endtask

    task automatic send_random(burst_kind_t kind);
        logic [2:0]       cmd;
        logic [CNT_W-1:0] cnt;
        int               u;
        int               p;
        u   = sb.fill();
        cnt = CNT_W'($urandom_range(0, DEPTH));
        p   = $urandom_range(0, 99);
        if (p < 2)
        begin
            cmd = CMD_RESET;
        end
        else if (p < 5)
        begin
            cmd = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        end
        else
        begin
            p = $urandom_range(0, 99);
            case (kind)
                FILL:
                begin
                    cmd = (p < 85) ? CMD_WRITE : (p < 90) ? CMD_READ :
                          (p < 95) ? CMD_PEEK : CMD_DISCARD;
                end
                DRAIN:
                begin
                    cmd = (p < 10) ? CMD_WRITE : (p < 55) ? CMD_READ :
                          (p < 75) ? CMD_PEEK : CMD_DISCARD;
                end
                default:
                begin
                    cmd = (p < 40) ? CMD_WRITE : (p < 70) ? CMD_READ :
                          (p < 88) ? CMD_PEEK : CMD_DISCARD;
                end
            endcase
        end
        // bias offsets and lengths towards the fill level and its edges
        p = $urandom_range(0, 99);
        if (p < 8)
        begin
            cnt = (p < 4) ? CNT_W'(u) : CNT_W'(DEPTH);
        end
        else if (cmd == CMD_PEEK && u > 0 && p < 80)
        begin
            cnt = CNT_W'($urandom_range(0, u - 1));
        end
        else if (cmd == CMD_DISCARD && p < 60)
        begin
            cnt = CNT_W'($urandom_range(0, (u < 8) ? 8 : u / 2));
        end
        send_op(cmd, BYTE_W'($urandom), cnt);
    endtask

    task automatic run_bursts(int n_items);
        burst_kind_t kind;
        int          len;
        while (n_items > 0)
        begin
            kind = burst_kind_t'($urandom_range(0, 2));
            len  = $urandom_range(4, 2 * int'(sb.mask()) + 8);
            if (len > n_items)
            begin
                len = n_items;
            end
            n_items -= len;
            repeat (len) send_random(kind);
            if ($urandom_range(0, 39) == 0)
            begin
                wait_idle();
            end
        end
    endtask

    // New size; without the reset command the indices just wrap to the new size.
    task automatic run_phase(logic [SIZE_W-1:0] size_log2, int n_items, bit with_reset);
        wait_idle();
        write_size(size_log2);
        steady = ($urandom_range(0, 3) == 0);
        if (with_reset)
        begin
            send_op(CMD_RESET, BYTE_W'($urandom), CNT_W'($urandom_range(0, DEPTH)));
        end
        run_bursts(n_items);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check(m_tdata);
        end
    end

    initial
    begin : out_stall
        int n;
        wait (rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat (steady ? 50 : $urandom_range(1, 12)) @(posedge clk);
            n = pause_len();
            if (!steady && n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, full size after reset
        send_op(CMD_READ, 8'h00, 9'd0);
        send_op(CMD_PEEK, 8'hFF, 9'd0);
        send_op(CMD_DISCARD, 8'h00, 9'd256);
        send_op(CMD_BAD_FIRST, 8'hFF, 9'd256);
        send_op(CMD_BAD_LAST, 8'h00, 9'd0);
        send_op(CMD_WRITE, 8'h00, 9'd0);
        send_op(CMD_WRITE, 8'hFF, 9'd256);
        send_op(CMD_WRITE, 8'h5A, 9'd0);
        send_op(CMD_PEEK, 8'h00, 9'd0);
        send_op(CMD_PEEK, 8'h00, 9'd2);
        send_op(CMD_PEEK, 8'h00, 9'd3);     // offset equal to fill: refused
        send_op(CMD_PEEK, 8'h00, 9'd256);
        send_op(CMD_READ, 8'h00, 9'd0);
        send_op(CMD_DISCARD, 8'h00, 9'd0);
        send_op(CMD_DISCARD, 8'h00, 9'd1);
        send_op(CMD_WRITE, 8'hA5, 9'd0);
        send_op(CMD_WRITE, 8'h3C, 9'd0);
        send_op(CMD_DISCARD, 8'h00, 9'd256); // clamped to what is stored
        send_op(CMD_WRITE, 8'hC3, 9'd0);
        send_op(CMD_RESET, 8'hFF, 9'd256);
        send_op(CMD_READ, 8'h00, 9'd0);
        send_op(CMD_BAD_LAST, 8'h00, 9'd0);

        // fill to full with two refused writes on top, then free one slot and write the
        // last store slot so every store entry holds a known byte
        repeat (DEPTH + 1) send_op(CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom_range(0, DEPTH)));
        send_op(CMD_READ, BYTE_W'($urandom), CNT_W'($urandom_range(0, DEPTH)));
        send_op(CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom_range(0, DEPTH)));
        run_bursts(140);

        run_phase(4'd0, 100, 1'b1);
        run_phase(4'd1, 100, 1'b1);
        run_phase(4'd2, 120, 1'b1);
        run_phase(4'd15, 150, 1'b0);
        run_phase(4'd3, 120, 1'b0);
        run_phase(4'd4, 130, 1'b1);
        run_phase(4'd9, 100, 1'b1);
        run_phase(4'd5, 120, 1'b1);
        run_phase(4'd6, 130, 1'b0);
        run_phase(4'd7, 150, 1'b1);
        run_phase(4'd8, 100, 1'b0);

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("[byte_ring_buffer] OK");
        end
        else
        begin
            $display("[byte_ring_buffer] ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("[byte_ring_buffer] ERROR");
        $finish;
    end

endmodule
